// ===== rtl/reck_pkg.sv =====
// Package: shared types and codes for the rotary encoder key command block
`timescale 1ns / 1ps

package reck_pkg;

    // Event kinds carried by an input item
    typedef enum logic [1:0] {
        KIND_PHASE = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_POLL  = 2'd2
    } t_kind;

    // Key press tracking
    typedef enum logic [1:0] {
        PRESS_RELEASED = 2'd0,
        PRESS_HELD     = 2'd1,
        PRESS_TURNED   = 2'd2
    } t_press;

    // Command codes
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_CLICK     = 3'd1;
    localparam logic [2:0] CMD_DOWN      = 3'd2;
    localparam logic [2:0] CMD_UP        = 3'd3;
    localparam logic [2:0] CMD_DOWN_HELD = 3'd4;
    localparam logic [2:0] CMD_UP_HELD   = 3'd5;

    // Phase codes, {phase_a, phase_b}
    localparam logic [1:0] PH_IDLE = 2'b00;
    localparam logic [1:0] PH_B    = 2'b01;
    localparam logic [1:0] PH_A    = 2'b10;
    localparam logic [1:0] PH_BOTH = 2'b11;

    // One registered input item
    typedef struct packed {
        logic [1:0] kind;
        logic       phase_a;
        logic       phase_b;
        logic       key_level;
    } t_item;

endpackage

// ===== rtl/reck_if.sv =====
// Interfaces: input event channel and command result channel
`timescale 1ns / 1ps

interface reck_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       phase_a;
    logic       phase_b;
    logic       key_level;

    modport source (output valid, output kind, output phase_a, output phase_b,
                    output key_level, input ready);
    modport sink   (input valid, input kind, input phase_a, input phase_b,
                    input key_level, output ready);
endinterface

interface reck_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;

    modport source (output valid, output command, input ready);
    modport sink   (input valid, input command, output ready);
endinterface

// ===== rtl/reck_in_stage.sv =====
// Input register: captures one event item and holds it until it advances
`timescale 1ns / 1ps

module reck_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    reck_in_if.sink         i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output reck_pkg::t_item o_item
);
    import reck_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    // Take a new item when empty or when the held one moves on
    assign i_item.ready = !r_valid || i_advance;
    assign w_take       = i_item.valid && i_item.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind      <= i_item.kind;
            r_item.phase_a   <= i_item.phase_a;
            r_item.phase_b   <= i_item.phase_b;
            r_item.key_level <= i_item.key_level;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== rtl/reck_core.sv =====
// Core: step counter, press tracking and command resolution for one item
`timescale 1ns / 1ps

module reck_core #(
    parameter int STEPS_PER_COMMAND = 4,
    parameter int COUNT_LIMIT       = 127
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  reck_pkg::t_item i_item,
    output logic            o_res_valid,
    output logic [2:0]      o_command
);
    import reck_pkg::*;

    localparam int CNT_W = $clog2(COUNT_LIMIT + 1) + 1;
    localparam logic signed [CNT_W-1:0] LIMIT = CNT_W'(COUNT_LIMIT);
    localparam logic signed [CNT_W-1:0] STEP  = CNT_W'(STEPS_PER_COMMAND);

    logic signed [CNT_W-1:0] r_count, n_count;
    logic [1:0]              r_last, n_last;
    logic                    r_rearm, n_rearm;
    t_press                  r_press, n_press;
    logic [2:0]              r_pending, n_pending;

    logic [1:0]              w_code;
    logic                    w_turned;
    t_press                  w_press_res;
    logic [2:0]              w_resolved;

    assign w_code = {i_item.phase_a, i_item.phase_b};

    // Resolve the count: quotient nonzero means at least one full detent
    always_comb begin
        w_turned    = (r_count >= STEP) || (r_count <= -STEP);
        w_press_res = r_press;
        w_resolved  = CMD_NONE;
        if (w_turned) begin
            if (r_press != PRESS_RELEASED) begin
                w_resolved  = r_count[CNT_W-1] ? CMD_DOWN_HELD : CMD_UP_HELD;
                w_press_res = PRESS_TURNED;
            end else begin
                w_resolved = r_count[CNT_W-1] ? CMD_DOWN : CMD_UP;
            end
        end
    end

    // Next state and result
    always_comb begin
        n_count     = r_count;
        n_last      = r_last;
        n_rearm     = r_rearm;
        n_press     = r_press;
        n_pending   = r_pending;
        o_res_valid = 1'b0;
        o_command   = CMD_NONE;
        if (i_fire) begin
            case (i_item.kind)
                KIND_PHASE: begin
                    // count a step on reaching 11 after passing 00
                    if (r_rearm && w_code == PH_BOTH) begin
                        if (r_last == PH_A && r_count < LIMIT) begin
                            n_count = r_count + CNT_W'(1);
                            n_rearm = 1'b0;
                        end else if (r_last == PH_B && r_count > -LIMIT) begin
                            n_count = r_count - CNT_W'(1);
                            n_rearm = 1'b0;
                        end
                    end
                    if (w_code == PH_IDLE) begin
                        n_rearm = 1'b1;
                    end
                    n_last = w_code;
                end
                KIND_KEY: begin
                    n_count = '0;
                    if (w_resolved == CMD_NONE && w_press_res == PRESS_HELD) begin
                        n_pending = CMD_CLICK;
                    end else begin
                        n_pending = w_resolved;
                    end
                    n_press = i_item.key_level ? PRESS_RELEASED : PRESS_HELD;
                end
                KIND_POLL: begin
                    n_count     = '0;
                    n_press     = w_press_res;
                    n_pending   = CMD_NONE;
                    o_res_valid = 1'b1;
                    o_command   = (w_resolved != CMD_NONE) ? w_resolved : r_pending;
                end
                default: begin
                    // unused kind: drop
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_last    <= PH_IDLE;
            r_rearm   <= 1'b0;
            r_press   <= PRESS_RELEASED;
            r_pending <= CMD_NONE;
        end else begin
            r_count   <= n_count;
            r_last    <= n_last;
            r_rearm   <= n_rearm;
            r_press   <= n_press;
            r_pending <= n_pending;
        end
    end
endmodule

// ===== rtl/rotary_encoder_key_command_top.sv =====
// Top level: rotary encoder and key to command converter
//
//  channel    modport  direction  payload
//  i_item     sink     in         kind[1:0], phase_a, phase_b, key_level
//  o_result   source   out        command[2:0]
//
// One item per cycle unless a poll waits on a stalled result. An item is held in
// the input register and applied to the encoder state as it leaves; a poll lands
// in the result register at that same edge, where its command is then valid.
// Reset clears the counter, phase history, press mode and pending command.
// A stalled result holds a poll in the input register and the input with it;
// other kinds never wait on the result.
`timescale 1ns / 1ps

module rotary_encoder_key_command_top #(
    parameter int STEPS_PER_COMMAND = 4,
    parameter int COUNT_LIMIT       = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    reck_in_if.sink     i_item,
    reck_out_if.source  o_result
);
    import reck_pkg::*;

    logic       w_stage_valid;
    t_item      w_stage_item;
    logic       w_out_free;
    logic       w_advance;
    logic       w_res_valid;
    logic [2:0] w_res_cmd;
    logic       r_out_valid;
    logic [2:0] r_out_cmd;

    // Input register
    reck_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    // Advance unless a poll finds the result register blocked
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_advance  = w_stage_valid && (w_stage_item.kind != KIND_POLL || w_out_free);

    reck_core #(
        .STEPS_PER_COMMAND (STEPS_PER_COMMAND),
        .COUNT_LIMIT       (COUNT_LIMIT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_advance),
        .i_item      (w_stage_item),
        .o_res_valid (w_res_valid),
        .o_command   (w_res_cmd)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_cmd <= w_res_cmd;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.command = r_out_cmd;

    // A result only appears after a poll left the input register
    a_result_from_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(w_res_valid))
        else $error("result without a poll");

    // Backpressure on the input means an item is held
    a_ready_low_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (w_stage_valid && !w_advance))
        else $error("input stalled while stage empty");

    // A poll never overwrites a result still waiting
    a_poll_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !w_res_valid)
        else $error("poll overran pending result");

    // Result reads back within command range
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cmd <= CMD_UP_HELD))
        else $error("command out of range");
endmodule

// ===== test/rotary_encoder_key_command_top_tb.sv =====
// Testbench: random and directed item streams checked against a behavioral command predictor
`timescale 1ns / 1ps

module rotary_encoder_key_command_top_tb;
    import reck_pkg::*;

    localparam int          STEPS_PER_COMMAND = 4;
    localparam int          COUNT_LIMIT       = 127;
    localparam int          CYCLE_LIMIT       = 400000;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam logic [1:0]  KIND_UNUSED       = 2'd3;

    // Predict commands from accepted items and match them against results
    class command_scoreboard;
        logic signed [7:0] step_count      = '0;
        logic [1:0]        last_phase      = PH_IDLE;
        logic              rearm           = 1'b0;
        t_press            press           = PRESS_RELEASED;
        logic [2:0]        pending_cmd     = CMD_NONE;
        logic [2:0]        expected_cmds[$];
        int                fail_count      = 0;

        // Turn the count into a command and clear it
        function logic [2:0] resolve_count();
            int         quot;
            logic [2:0] cmd;
            quot = int'(step_count) / STEPS_PER_COMMAND;
            cmd  = CMD_NONE;
            if (quot != 0) begin
                cmd = (quot < 0) ? CMD_DOWN : CMD_UP;
                if (press != PRESS_RELEASED) begin
                    cmd   = (quot < 0) ? CMD_DOWN_HELD : CMD_UP_HELD;
                    press = PRESS_TURNED;
                end
            end
            step_count = '0;
            return cmd;
        endfunction

        // Advance the step counter on a full quadrature cycle
        function void take_phase(logic [1:0] code);
            logic signed [7:0] prev;
            if (rearm && code == PH_BOTH) begin
                prev = step_count;
                if (last_phase == PH_A) begin
                    if (step_count < COUNT_LIMIT) step_count++;
                end else if (last_phase == PH_B) begin
                    if (step_count > -COUNT_LIMIT) step_count--;
                end
                if (prev != step_count) rearm = 1'b0;
            end
            if (code == PH_IDLE) rearm = 1'b1;
            last_phase = code;
        endfunction

        function void note_item(logic [1:0] kind, logic a, logic b, logic key_level);
            logic [2:0] cmd;
            case (kind)
                KIND_PHASE: begin
                    take_phase({a, b});
                end
                KIND_KEY: begin
                    cmd = resolve_count();
                    if (cmd == CMD_NONE && press == PRESS_HELD) cmd = CMD_CLICK;
                    pending_cmd = cmd;
                    press = key_level ? PRESS_RELEASED : PRESS_HELD;
                end
                KIND_POLL: begin
                    cmd = resolve_count();
                    if (cmd == CMD_NONE) cmd = pending_cmd;
                    pending_cmd = CMD_NONE;
                    expected_cmds.push_back(cmd);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [2:0] cmd);
            logic [2:0] want;
            if (expected_cmds.size() == 0) begin
                $error("unexpected result: command %0d with nothing pending", cmd);
                fail_count++;
            end else begin
                want = expected_cmds.pop_front();
                if (cmd !== want) begin
                    $error("command mismatch: expected %0d, actual %0d", want, cmd);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    reck_in_if  item_if ();
    reck_out_if result_if ();

    rotary_encoder_key_command_top #(
        .STEPS_PER_COMMAND(STEPS_PER_COMMAND),
        .COUNT_LIMIT      (COUNT_LIMIT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    command_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int hold_ticket   = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    always #5 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receive results; stall at random or for a long stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) sb.check_result(result_if.command);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one item, idle first at random, and hold it until taken
    task automatic send_item(logic [1:0] kind, logic a, logic b, logic key_level);
        if ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_if.valid     <= 1'b1;
        item_if.kind      <= kind;
        item_if.phase_a   <= a;
        item_if.phase_b   <= b;
        item_if.key_level <= key_level;
        do @(posedge i_clk); while (!item_if.ready);
        sb.note_item(kind, a, b, key_level);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic send_phase(logic [1:0] code);
        send_item(KIND_PHASE, code[1], code[0], 1'($urandom_range(1)));
    endtask

    task automatic send_key(logic key_level);
        send_item(KIND_KEY, 1'($urandom_range(1)), 1'($urandom_range(1)), key_level);
    endtask

    task automatic send_poll();
        send_item(KIND_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    // Turn the knob by whole detents, with an occasional bounce on the middle code
    task automatic rotate_steps(bit go_up, int steps);
        int n;
        for (n = 0; n < steps; n++) begin
            send_phase(PH_IDLE);
            send_phase(go_up ? PH_A : PH_B);
            if ($urandom_range(9) == 0) send_phase(go_up ? PH_A : PH_B);
            send_phase(PH_BOTH);
        end
    endtask

    // Pick one random action: mostly clean rotation, some key and poll traffic, some noise
    task automatic random_action();
        int pick;
        int steps;
        pick = $urandom_range(99);
        if (pick < 45) begin
            steps = ($urandom_range(99) < 3) ? $urandom_range(128, 135) : $urandom_range(1, 9);
            rotate_steps(1'($urandom_range(1)), steps);
        end else if (pick < 60) begin
            send_key(1'($urandom_range(1)));
        end else if (pick < 80) begin
            send_poll();
        end else if (pick < 92) begin
            send_phase(2'($urandom_range(3)));
        end else if (pick < 96) begin
            // broken detent: turn half way and go back, or jump straight to both high
            if ($urandom_range(1)) begin
                send_phase(PH_IDLE);
                send_phase($urandom_range(1) ? PH_A : PH_B);
                send_phase(PH_IDLE);
            end else begin
                send_phase($urandom_range(1) ? PH_A : PH_B);
                send_phase(PH_BOTH);
            end
        end else begin
            send_item(KIND_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(int target);
        while (items_sent < target) random_action();
    endtask

    initial begin
        sb = new;
        i_rst_n           <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.kind      <= KIND_PHASE;
        item_if.phase_a   <= 1'b0;
        item_if.phase_b   <= 1'b0;
        item_if.key_level <= 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: poll at reset, ignored kind, click, four steps up, then a press and release
        send_poll();
        send_item(KIND_UNUSED, 1'b1, 1'b1, 1'b0);
        send_key(1'b0);
        send_key(1'b1);
        send_poll();
        rotate_steps(1'b1, 4);
        send_key(1'b0);
        send_poll();
        send_key(1'b1);
        send_poll();

        // Sender idles lightly, receiver heavily
        send_idle_pct = 15;
        recv_idle_pct = 59;
        run_random(640);

        // Swap the idle rates
        send_idle_pct = 59;
        recv_idle_pct = 15;
        run_random(1260);

        // No idling; open with a long receiver hold-off while polls keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ticket <= hold_ticket + 1;
        repeat (30) begin
            send_poll();
            send_phase(2'($urandom_range(3)));
        end
        run_random(1870);
        item_if.valid <= 1'b0;

        // Drain remaining commands, then let the pipeline settle
        while (sb.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== rotary_encoder_key_command_top.f =====
rtl/reck_pkg.sv
rtl/reck_if.sv
rtl/reck_in_stage.sv
rtl/reck_core.sv
rtl/rotary_encoder_key_command_top.sv
test/rotary_encoder_key_command_top_tb.sv
